/* hw/rtl/atu_pkg.sv */
package atu_pkg;

    localparam int HIST_DEPTH = 14;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;

    localparam logic [4:0] CNT_UTC = 5'd12;
    localparam logic [4:0] CNT_GEN = 5'd14;
    localparam logic [4:0] CNT_MAX = 5'd31;

    // shift by one era so the year stays positive
    localparam logic [13:0] YEAR_SHIFT = 14'd400;
    localparam logic [23:0] DAYS_BIAS  = 24'd865565;
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          RECIP_SH   = 19;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } job_t;

    function automatic logic [6:0] pair_val(input logic [3:0] hi, input logic [3:0] lo);
        logic [6:0] h7;
        h7 = {3'b000, hi};
        return (h7 << 3) + (h7 << 1) + {3'b000, lo};
    endfunction

    // days from march 1 to the first of the month
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/asn1_time_to_unix_seconds_unit.sv */
// asn1 time string to unix seconds
// slave channel: one ascii character per item in s_tdata[7:0], s_tlast high on the
// final character of a utctime or generalizedtime string
// master channel: one item per string, on its final character; m_tdata[1:0] is the
// status (ok, bad length or no z, field out of range, non-digit) and m_tdata[40:2]
// the signed seconds since 1970, zero unless the status is ok
// the input takes one character per cycle while the job queue is not full; a string's
// final character is classified and queued, and a sequential calendar unit raises
// m_tvalid once the job has passed through its cal, mul, sum, sec and done states
// the calendar unit works on one string at a time, so short strings can outrun it; a
// two-entry job queue absorbs such bursts and s_tready drops only while that queue is
// full
// a stall on m_tready holds the result register; the unit waits with the next result
// and the queue fills before the input side stops
// reset clears the character count, the non-digit flag, the queue and the output
// valid; the next character after reset starts a new string
module asn1_time_to_unix_seconds_unit import atu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // time_status, unix_seconds, zero pad
);

    job_t wr_job;
    job_t rd_job;
    logic push, pop, full, empty;

    atu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .full     (full),
        .push     (push),
        .job      (wr_job)
    );

    atu_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .full   (full),
        .empty  (empty)
    );

    atu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .rd_job   (rd_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hw/rtl/atu_front.sv */
module atu_front import atu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       full,
    output logic       push,
    output job_t       job
);

    logic [3:0] hist_reg [HIST_DEPTH];
    logic [4:0] count_reg, count_next;
    logic       nd_reg, nd_next;
    logic       accept;
    logic       is_digit;
    logic [6:0] p0, p2, p4, p6, p8, p10, p12;
    logic [13:0] year13, year15;
    logic       len_ok, range_bad;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;
    assign push     = accept && s_tlast;
    assign is_digit = (s_tdata >= CHAR_0) && (s_tdata <= CHAR_9);

    assign p0  = pair_val(hist_reg[0],  hist_reg[1]);
    assign p2  = pair_val(hist_reg[2],  hist_reg[3]);
    assign p4  = pair_val(hist_reg[4],  hist_reg[5]);
    assign p6  = pair_val(hist_reg[6],  hist_reg[7]);
    assign p8  = pair_val(hist_reg[8],  hist_reg[9]);
    assign p10 = pair_val(hist_reg[10], hist_reg[11]);
    assign p12 = pair_val(hist_reg[12], hist_reg[13]);

    assign year13 = (p2 < 7'd50) ? (14'd2000 + 14'(p2)) : (14'd1900 + 14'(p2));
    assign year15 = 14'(14'(p0) * 14'd100) + 14'(p2);

    always_comb
    begin
        len_ok    = (count_reg inside {CNT_UTC, CNT_GEN}) && (s_tdata == CHAR_Z);
        range_bad = (p4 < 7'd1) || (p4 > 7'd12) || (p6 < 7'd1) || (p6 > 7'd31)
                    || (p8 > 7'd23) || (p10 > 7'd59) || (p12 > 7'd60);
        job.year   = (count_reg == CNT_UTC) ? year13 : year15;
        job.month  = p4[3:0];
        job.day    = p6[4:0];
        job.hour   = p8[4:0];
        job.minute = p10[5:0];
        job.second = p12[5:0];
        if (!len_ok)
        begin
            job.status = ST_LEN;
        end
        else if (nd_reg)
        begin
            job.status = ST_DIGIT;
        end
        else if (range_bad)
        begin
            job.status = ST_RANGE;
        end
        else
        begin
            job.status = ST_OK;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        nd_next    = nd_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                count_next = '0;
                nd_next    = 1'b0;
            end
            else
            begin
                if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + 5'd1;
                end
                if (!is_digit)
                begin
                    nd_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            nd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            nd_reg    <= nd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !s_tlast)
        begin
            for (int i = 0; i < HIST_DEPTH - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i + 1];
            end
            hist_reg[HIST_DEPTH - 1] <= s_tdata[3:0];
        end
    end

endmodule

/* hw/rtl/atu_fifo.sv */
module atu_fifo import atu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    input  logic pop,
    output job_t rd_job,
    output logic full,
    output logic empty
);

    localparam int PW = $clog2(FIFO_DEPTH);

    job_t          mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full   = (cnt_reg == (PW + 1)'(FIFO_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (PW + 1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wr_job;
        end
    end

endmodule

/* hw/rtl/atu_back.sv */
module atu_back import atu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  job_t        rd_job,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata  // time_status, unix_seconds, zero pad
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_CAL  = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_SUM  = 3'd3;
    localparam logic [2:0] B_SEC  = 3'd4;
    localparam logic [2:0] B_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic               ovalid_reg, ovalid_next;
    job_t               job_reg;
    logic [13:0]        yy_reg;
    logic [8:0]         doy_reg;
    logic [16:0]        hms_reg;
    logic [6:0]         c_reg;
    logic [21:0]        t365_reg;
    logic signed [23:0] days_reg;
    logic [38:0]        secs_reg;
    logic [1:0]         ostat_reg;
    logic [38:0]        osecs_reg;
    logic [26:0]        q_prod;
    logic signed [40:0] d_prod;
    logic               out_free;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign out_free = !ovalid_reg || m_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'd0, osecs_reg, ostat_reg};
    assign q_prod   = 27'(yy_reg) * 27'(RECIP_100);
    assign d_prod   = 41'(days_reg) * 41'sd86400;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_CAL;
                end
            end
            B_CAL:  state_next = B_MUL;
            B_MUL:  state_next = B_SUM;
            B_SUM:  state_next = B_SEC;
            B_SEC:  state_next = B_DONE;
            B_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= rd_job;
        end
        if (state_reg == B_CAL)
        begin
            yy_reg  <= job_reg.year + YEAR_SHIFT - ((job_reg.month <= 4'd2) ? 14'd1 : 14'd0);
            doy_reg <= month_offset(job_reg.month) + 9'(job_reg.day) - 9'd1;
            hms_reg <= 17'(17'(job_reg.hour) * 17'd3600) + 17'(17'(job_reg.minute) * 17'd60)
                       + 17'(job_reg.second);
        end
        if (state_reg == B_MUL)
        begin
            c_reg    <= q_prod[RECIP_SH +: 7];
            t365_reg <= 22'(22'(yy_reg) * 22'd365);
        end
        if (state_reg == B_SUM)
        begin
            days_reg <= $signed(24'(t365_reg) + 24'(yy_reg >> 2) + 24'(c_reg >> 2)
                        + 24'(doy_reg) - 24'(c_reg) - DAYS_BIAS);
        end
        if (state_reg == B_SEC)
        begin
            secs_reg <= d_prod[38:0] + 39'(hms_reg);
        end
        if ((state_reg == B_DONE) && out_free)
        begin
            ostat_reg <= job_reg.status;
            osecs_reg <= (job_reg.status == ST_OK) ? secs_reg : '0;
        end
    end

endmodule
